@@ rtl/pfa_pkg.sv @@
// Shared request, status and compare-unit codes for the partition fit allocator.
`default_nettype none

package pfa_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_MERGE
  } eval_op_t;

  typedef struct packed {
    eval_op_t op;
    logic     found;
    logic     fit_mode;
  } eval_ctl_t;

endpackage

`default_nettype wire

@@ rtl/pfa_eval.sv @@
// Shared compare unit: fit test, start match and merge test on two table entries.
`default_nettype none

module pfa_eval #(
  parameter int ADDR_BITS = 16
) (
  input  wire pfa_pkg::eval_ctl_t  ctl,
  input  wire logic [2*ADDR_BITS:0] ent_a,
  input  wire logic [2*ADDR_BITS:0] ent_b,
  input  wire logic [ADDR_BITS-1:0] req_start,
  input  wire logic [ADDR_BITS-1:0] req_size,
  output logic                     hit,
  output logic [ADDR_BITS-1:0]     sum
);

  logic [ADDR_BITS-1:0] a_start, a_size, b_start, b_size;
  logic                 a_used, b_used;
  logic [ADDR_BITS:0]   a_end, sum_full;

  assign a_start = ent_a[ADDR_BITS-1:0];
  assign a_size  = ent_a[2*ADDR_BITS-1:ADDR_BITS];
  assign a_used  = ent_a[2*ADDR_BITS];
  assign b_start = ent_b[ADDR_BITS-1:0];
  assign b_size  = ent_b[2*ADDR_BITS-1:ADDR_BITS];
  assign b_used  = ent_b[2*ADDR_BITS];

  // End address and merged size, both kept one bit wider to see overflow.
  assign a_end    = {1'b0, a_start} + {1'b0, a_size};
  assign sum_full = {1'b0, a_size} + {1'b0, b_size};
  assign sum      = sum_full[ADDR_BITS-1:0];

  always_comb begin
    hit = 1'b0;
    case (ctl.op)
      pfa_pkg::OP_ALLOC: begin
        if (!a_used && (a_size >= req_size)) begin
          if (!ctl.found) begin
            hit = 1'b1;
          end else if (!ctl.fit_mode) begin
            hit = (a_size < b_size);
          end else begin
            hit = (a_size > b_size);
          end
        end
      end
      pfa_pkg::OP_FREE: begin
        hit = (a_start == req_start);
      end
      pfa_pkg::OP_MERGE: begin
        hit = !a_used && !b_used && (a_end == {1'b0, b_start}) && !sum_full[ADDR_BITS];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/partition_fit_allocator.sv @@
// Top level: partition table, request sequencer and result register.
// Add and unknown requests go through S_CMD to the out_valid strobe; allocate and free
// scan the table first, one table read per cycle; a free may then test merges, and a split
// or a merge moves entries before the strobe.
// Throughput: one item at a time; busy stays high until its result is strobed.
// Reset (rst_n low, synchronous): clears entry count, fit_mode and control; table undefined.
`default_nettype none

module partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 8,
  parameter int ADDR_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_start_addr,
  input  wire logic [15:0] in_req_size,
  input  wire logic        in_mark_used,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_block_start,
  output logic [15:0]      out_block_size,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  // Entry layout: {used, size, start}.
  localparam int EW = 2 * ADDR_BITS + 1;
  localparam int IW = $clog2(MAX_PARTITIONS);
  localparam int CW = $clog2(MAX_PARTITIONS + 2);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PARTITIONS);

  typedef enum logic [3:0] {
    S_IDLE,   // wait for an item
    S_CMD,    // add or unknown request
    S_SCAN,   // stream the table through the compare unit
    S_ADEC,   // allocate decision
    S_SHR,    // open a slot after the picked entry
    S_AREM,   // write the split remainder
    S_APICK,  // write the picked entry as used
    S_FDEC,   // free decision
    S_FM1,    // try merge with the next entry
    S_FM2,    // try merge with the previous entry, write back
    S_SHL     // close the gap left by merged entries
  } state_t;

  // Control and output registers.
  state_t      state_r, state_nxt;
  logic        fit_mode_r, fit_mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_block_start_r, out_block_start_nxt;
  logic [15:0] out_block_size_r, out_block_size_nxt;

  // Datapath registers.
  logic [1:0]           req_type_r, req_type_nxt;
  logic [ADDR_BITS-1:0] req_start_r, req_start_nxt;
  logic [ADDR_BITS-1:0] req_size_r, req_size_nxt;
  logic                 mark_used_r, mark_used_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic [CW-1:0]        pidx_r, pidx_nxt;
  logic                 found_r, found_nxt;
  logic [EW-1:0]        pick_r, pick_nxt;
  logic [CW-1:0]        pick_idx_r, pick_idx_nxt;
  logic [EW-1:0]        m_r, m_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [EW-1:0]        p_r, p_nxt;
  logic [EW-1:0]        n_r, n_nxt;
  logic [EW-1:0]        last_r, last_nxt;
  logic                 has_next_r, has_next_nxt;
  logic                 grab_next_r, grab_next_nxt;
  logic [ADDR_BITS-1:0] cur_size_r, cur_size_nxt;
  logic                 mrg_next_r, mrg_next_nxt;
  logic [CW-1:0]        src_r, src_nxt;
  logic [CW-1:0]        dst_r, dst_nxt;
  logic [CW-1:0]        shk_r, shk_nxt;

  // Table memory: one write port, one registered read port.
  logic [EW-1:0] mem [MAX_PARTITIONS];
  logic [EW-1:0] mem_q_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [IW-1:0] rd_addr;

  // Shared compare unit.
  pfa_pkg::eval_ctl_t   ectl;
  logic [EW-1:0]        ea, eb;
  logic                 ehit;
  logic [ADDR_BITS-1:0] esum;

  pfa_eval #(
    .ADDR_BITS(ADDR_BITS)
  ) u_eval (
    .ctl      (ectl),
    .ent_a    (ea),
    .ent_b    (eb),
    .req_start(req_start_r),
    .req_size (req_size_r),
    .hit      (ehit),
    .sum      (esum)
  );

  // Field views of the registered entries.
  logic [ADDR_BITS-1:0] pick_start, pick_size, m_start, m_size, p_start;
  logic                 m_used, is_alloc;

  assign pick_start = pick_r[ADDR_BITS-1:0];
  assign pick_size  = pick_r[2*ADDR_BITS-1:ADDR_BITS];
  assign m_start    = m_r[ADDR_BITS-1:0];
  assign m_size     = m_r[2*ADDR_BITS-1:ADDR_BITS];
  assign m_used     = m_r[2*ADDR_BITS];
  assign p_start    = p_r[ADDR_BITS-1:0];
  assign is_alloc   = (req_type_r == pfa_pkg::REQ_ALLOC);

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_block_start_r;
  assign out_block_size  = out_block_size_r;

  always_comb begin
    logic          prv;
    logic [CW-1:0] k;
    prv = 1'b0;
    k   = '0;

    state_nxt           = state_r;
    fit_mode_nxt        = fit_mode_r;
    count_nxt           = count_r;
    pend_nxt            = pend_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_block_start_nxt = out_block_start_r;
    out_block_size_nxt  = out_block_size_r;
    req_type_nxt        = req_type_r;
    req_start_nxt       = req_start_r;
    req_size_nxt        = req_size_r;
    mark_used_nxt       = mark_used_r;
    iss_nxt             = iss_r;
    pidx_nxt            = pidx_r;
    found_nxt           = found_r;
    pick_nxt            = pick_r;
    pick_idx_nxt        = pick_idx_r;
    m_nxt               = m_r;
    idx_nxt             = idx_r;
    p_nxt               = p_r;
    n_nxt               = n_r;
    last_nxt            = last_r;
    has_next_nxt        = has_next_r;
    grab_next_nxt       = grab_next_r;
    cur_size_nxt        = cur_size_r;
    mrg_next_nxt        = mrg_next_r;
    src_nxt             = src_r;
    dst_nxt             = dst_r;
    shk_nxt             = shk_r;

    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = '0;
    rd_addr = '0;

    ectl.op       = pfa_pkg::OP_ALLOC;
    ectl.found    = found_r;
    ectl.fit_mode = fit_mode_r;
    ea            = mem_q_r;
    eb            = pick_r;

    if (cfg_wr_en) begin
      fit_mode_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          // Latch the item, masked to the table address width.
          req_type_nxt  = in_req_type;
          req_start_nxt = ADDR_BITS'(in_start_addr);
          req_size_nxt  = ADDR_BITS'(in_req_size);
          mark_used_nxt = in_mark_used;
          iss_nxt       = '0;
          pend_nxt      = 1'b0;
          found_nxt     = 1'b0;
          grab_next_nxt = 1'b0;
          has_next_nxt  = 1'b0;
          if ((in_req_type == pfa_pkg::REQ_ALLOC) || (in_req_type == pfa_pkg::REQ_FREE)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end

      S_CMD: begin
        out_valid_nxt       = 1'b1;
        out_block_start_nxt = '0;
        out_block_size_nxt  = '0;
        state_nxt           = S_IDLE;
        if (req_type_r == pfa_pkg::REQ_ADD) begin
          if (count_r >= MAXC) begin
            out_status_nxt = pfa_pkg::ST_FULL;
          end else begin
            // Append at the end of the table.
            mem_we         = 1'b1;
            mem_wa         = count_r[IW-1:0];
            mem_wd         = {mark_used_r, req_size_r, req_start_r};
            count_nxt      = count_r + CW'(1);
            out_status_nxt = pfa_pkg::ST_OK;
          end
        end else begin
          out_status_nxt = pfa_pkg::ST_NOTFOUND;
        end
      end

      S_SCAN: begin
        ectl.op = is_alloc ? pfa_pkg::OP_ALLOC : pfa_pkg::OP_FREE;
        // Issue one read per cycle; evaluate the entry from the previous read.
        if (iss_r < count_r) begin
          rd_addr  = iss_r[IW-1:0];
          iss_nxt  = iss_r + CW'(1);
          pidx_nxt = iss_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (is_alloc) begin
            if (ehit) begin
              found_nxt    = 1'b1;
              pick_nxt     = mem_q_r;
              pick_idx_nxt = pidx_r;
            end
          end else begin
            // Keep the neighbors of the first matching start.
            last_nxt = mem_q_r;
            if (!found_r && ehit) begin
              found_nxt     = 1'b1;
              m_nxt         = mem_q_r;
              idx_nxt       = pidx_r;
              p_nxt         = last_r;
              grab_next_nxt = 1'b1;
            end else if (grab_next_r) begin
              n_nxt         = mem_q_r;
              has_next_nxt  = 1'b1;
              grab_next_nxt = 1'b0;
            end
          end
        end
        if (!pend_r && (iss_r >= count_r)) begin
          state_nxt = is_alloc ? S_ADEC : S_FDEC;
        end
      end

      S_ADEC: begin
        if (!found_r) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_NOFIT;
          out_block_start_nxt = '0;
          out_block_size_nxt  = '0;
          state_nxt           = S_IDLE;
        end else if (pick_size == req_size_r) begin
          // Exact fit: take the entry whole.
          mem_we              = 1'b1;
          mem_wa              = pick_idx_r[IW-1:0];
          mem_wd              = {1'b1, pick_size, pick_start};
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_OK;
          out_block_start_nxt = 16'(pick_start);
          out_block_size_nxt  = 16'(pick_size);
          state_nxt           = S_IDLE;
        end else if (count_r >= MAXC) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_FULL;
          out_block_start_nxt = '0;
          out_block_size_nxt  = '0;
          state_nxt           = S_IDLE;
        end else begin
          src_nxt   = count_r - CW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_SHR;
        end
      end

      S_SHR: begin
        // Move entries up by one, from the top down to just past the pick.
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = dst_r[IW-1:0];
          mem_wd = mem_q_r;
        end
        if (src_r > pick_idx_r) begin
          rd_addr  = src_r[IW-1:0];
          dst_nxt  = src_r + CW'(1);
          src_nxt  = src_r - CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_AREM;
        end
      end

      S_AREM: begin
        mem_we    = 1'b1;
        mem_wa    = IW'(pick_idx_r + CW'(1));
        mem_wd    = {1'b0, pick_size - req_size_r, pick_start + req_size_r};
        state_nxt = S_APICK;
      end

      S_APICK: begin
        mem_we              = 1'b1;
        mem_wa              = pick_idx_r[IW-1:0];
        mem_wd              = {1'b1, req_size_r, pick_start};
        count_nxt           = count_r + CW'(1);
        out_valid_nxt       = 1'b1;
        out_status_nxt      = pfa_pkg::ST_OK;
        out_block_start_nxt = 16'(pick_start);
        out_block_size_nxt  = 16'(req_size_r);
        state_nxt           = S_IDLE;
      end

      S_FDEC: begin
        if (!found_r || !m_used) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_NOTFOUND;
          out_block_start_nxt = '0;
          out_block_size_nxt  = '0;
          state_nxt           = S_IDLE;
        end else begin
          cur_size_nxt = m_size;
          mrg_next_nxt = 1'b0;
          state_nxt    = S_FM1;
        end
      end

      S_FM1: begin
        ectl.op = pfa_pkg::OP_MERGE;
        ea      = {1'b0, m_size, m_start};
        eb      = n_r;
        if (has_next_r && ehit) begin
          cur_size_nxt = esum;
          mrg_next_nxt = 1'b1;
        end
        state_nxt = S_FM2;
      end

      S_FM2: begin
        ectl.op = pfa_pkg::OP_MERGE;
        ea      = p_r;
        eb      = {1'b0, cur_size_r, m_start};
        prv     = (idx_r != '0) && ehit;
        mem_we  = 1'b1;
        if (prv) begin
          mem_wa = IW'(idx_r - CW'(1));
          mem_wd = {1'b0, esum, p_start};
        end else begin
          mem_wa = idx_r[IW-1:0];
          mem_wd = {1'b0, cur_size_r, m_start};
        end
        k = CW'(prv) + CW'(mrg_next_r);
        if (k == '0) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_OK;
          out_block_start_nxt = 16'(req_start_r);
          out_block_size_nxt  = '0;
          state_nxt           = S_IDLE;
        end else begin
          shk_nxt   = k;
          src_nxt   = idx_r + CW'(1) + CW'(mrg_next_r);
          pend_nxt  = 1'b0;
          state_nxt = S_SHL;
        end
      end

      S_SHL: begin
        // Move the entries above the merged ones down by the merge count.
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = dst_r[IW-1:0];
          mem_wd = mem_q_r;
        end
        if (src_r < count_r) begin
          rd_addr  = src_r[IW-1:0];
          dst_nxt  = src_r - shk_r;
          src_nxt  = src_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt            = 1'b0;
          count_nxt           = count_r - shk_r;
          out_valid_nxt       = 1'b1;
          out_status_nxt      = pfa_pkg::ST_OK;
          out_block_start_nxt = 16'(req_start_r);
          out_block_size_nxt  = '0;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      fit_mode_r        <= 1'b0;
      count_r           <= '0;
      pend_r            <= 1'b0;
      out_valid_r       <= 1'b0;
      out_status_r      <= pfa_pkg::ST_OK;
      out_block_start_r <= '0;
      out_block_size_r  <= '0;
    end else begin
      state_r           <= state_nxt;
      fit_mode_r        <= fit_mode_nxt;
      count_r           <= count_nxt;
      pend_r            <= pend_nxt;
      out_valid_r       <= out_valid_nxt;
      out_status_r      <= out_status_nxt;
      out_block_start_r <= out_block_start_nxt;
      out_block_size_r  <= out_block_size_nxt;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    req_type_r  <= req_type_nxt;
    req_start_r <= req_start_nxt;
    req_size_r  <= req_size_nxt;
    mark_used_r <= mark_used_nxt;
    iss_r       <= iss_nxt;
    pidx_r      <= pidx_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    pick_idx_r  <= pick_idx_nxt;
    m_r         <= m_nxt;
    idx_r       <= idx_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    last_r      <= last_nxt;
    has_next_r  <= has_next_nxt;
    grab_next_r <= grab_next_nxt;
    cur_size_r  <= cur_size_nxt;
    mrg_next_r  <= mrg_next_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    shk_r       <= shk_nxt;
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC)
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without an item in progress");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("entry count changed without a result");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_wa) < MAXC))
    else $error("table write beyond depth");
`endif

endmodule

`default_nettype wire
